// ===== rtl/hmr_pkg.sv =====
// Package with constants, types and helpers for the HID message reassembler.
package hmr_pkg;

    localparam int PACKET_BYTES_DEF = 64;
    localparam logic [31:0] BROADCAST_CH = 32'hFFFF_FFFF;
    localparam logic [6:0] CMD_INIT = 7'h06;
    localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd500;
    localparam logic [12:0] MAX_LEN_RST = 13'd1024;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_NONCE   = 2'd2,
        MODE_DISCARD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2,
        KIND_INIT     = 2'd3
    } kind_t;

    localparam logic [6:0] ERR_CHANNEL = 7'd0;
    localparam logic [6:0] ERR_BUSY    = 7'd1;
    localparam logic [6:0] ERR_SEQ     = 7'd2;
    localparam logic [6:0] ERR_LEN     = 7'd3;
    localparam logic [6:0] ERR_TIMEOUT = 7'd4;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAXLEN  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] channel;
        logic [6:0]  value;
        logic [12:0] length;
        logic [63:0] nonce;
        logic [31:0] new_channel;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [0:0]  index;
        logic [15:0] data;
    } cfg_item_t;

    function automatic out_item_t mk_ev(logic [1:0] k, logic [31:0] ch, logic [6:0] v,
                                        logic [12:0] len, logic [63:0] nc, logic [31:0] nch);
        out_item_t r;
        r.kind = k;
        r.channel = ch;
        r.value = v;
        r.length = len;
        r.nonce = nc;
        r.new_channel = nch;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/hmr_stream_if.sv =====
// Valid/ready stream interfaces for items, results and configuration writes.
interface hmr_in_if;
    import hmr_pkg::*;
    logic valid;
    logic ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hmr_out_if;
    import hmr_pkg::*;
    logic valid;
    logic ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hmr_cfg_if;
    import hmr_pkg::*;
    logic valid;
    logic ready;
    cfg_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/hid_message_reassembler.sv =====
// Top level of the HID message reassembler.
// Each accepted beat is decoded combinationally; its results (at most two) are
// registered into an output queue and appear there in the cycle after the beat.
// Throughput is one beat per cycle while the queue drains one result per cycle;
// a beat that makes two results fills the queue, which stalls input while it is full.
// Reset is asynchronous, active low, and restores all transport state and registers.
module hid_message_reassembler
    import hmr_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    hmr_in_if.sink   in_ch,
    hmr_out_if.source out_ch,
    hmr_cfg_if.sink  cfg
);
    localparam int PW = $clog2(PACKET_BYTES);
    localparam logic [PW-1:0] LAST_POS = PW'(PACKET_BYTES - 1);

    logic [15:0] timeout_reg;
    logic [12:0] maxlen_reg;
    logic [PW-1:0] pos_reg, pos_next;
    logic [55:0] hdr_reg, hdr_next;
    mode_t mode_reg, mode_next;
    logic [31:0] ach_reg, ach_next;
    logic [6:0] acmd_reg, acmd_next;
    logic [15:0] exp_reg, exp_next;
    logic [15:0] rcv_reg, rcv_next;
    logic [6:0] seq_reg, seq_next;
    logic ovf_reg, ovf_next;
    logic [15:0] ms_reg, ms_next;
    logic [31:0] free_reg, free_next;
    logic [63:0] nonce_reg, nonce_next;

    // Two-entry result queue.
    out_item_t q_reg [2];
    logic [1:0] cnt_reg;
    out_item_t ev0, ev1;
    logic [1:0] nev;

    logic acc;
    assign cfg.ready = 1'b1;
    assign in_ch.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ch.ready);
    assign acc = in_ch.valid && in_ch.ready;
    assign out_ch.valid = (cnt_reg != 2'd0);
    assign out_ch.payload = q_reg[0];

    always_comb
    begin
        logic [7:0] d;
        logic [31:0] ch;
        logic [6:0] cmd;
        logic [15:0] len;
        logic [2:0] k;
        logic [31:0] fi;
        logic [15:0] rinc;
        out_item_t e [2];
        logic [1:0] n;
        d = in_ch.payload.data;
        pos_next = pos_reg;
        hdr_next = hdr_reg;
        mode_next = mode_reg;
        ach_next = ach_reg;
        acmd_next = acmd_reg;
        exp_next = exp_reg;
        rcv_next = rcv_reg;
        seq_next = seq_reg;
        ovf_next = ovf_reg;
        ms_next = ms_reg;
        free_next = free_reg;
        nonce_next = nonce_reg;
        e[0] = '0;
        e[1] = '0;
        n = 2'd0;
        ch = '0;
        cmd = '0;
        len = '0;
        k = '0;
        fi = '0;
        rinc = '0;
        if (in_ch.payload.op)
        begin
            if (ach_reg != '0 && rcv_reg < exp_reg)
            begin
                if (ms_reg != 16'hFFFF)
                    ms_next = ms_reg + 16'd1;
                if (ms_next > timeout_reg)
                begin
                    ach_next = '0; acmd_next = '0; exp_next = '0; rcv_next = '0;
                    seq_next = '0; ovf_next = 1'b0;
                    if (mode_reg == MODE_PAYLOAD)
                        mode_next = MODE_DISCARD;
                    e[0] = mk_ev(KIND_ERROR, ach_reg, ERR_TIMEOUT, '0, '0, '0);
                    n = 2'd1;
                end
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_HEADER:
                begin
                    hdr_next = {hdr_reg[47:0], d};
                    if (pos_reg == PW'(4))
                    begin
                        ch = hdr_next[39:8];
                        if (ch == '0)
                            mode_next = MODE_DISCARD;
                        else if (!d[7])
                        begin
                            mode_next = MODE_DISCARD;
                            if (ach_reg == '0 || ch != ach_reg)
                            begin
                                e[0] = mk_ev(KIND_ERROR, ch, ERR_CHANNEL, '0, '0, '0);
                                n = 2'd1;
                            end
                            else if ({1'b0, d[6:0]} != {1'b0, seq_reg})
                            begin
                                ach_next = '0; acmd_next = '0; exp_next = '0;
                                rcv_next = '0; seq_next = '0; ovf_next = 1'b0;
                                e[0] = mk_ev(KIND_ERROR, ch, ERR_SEQ, '0, '0, '0);
                                n = 2'd1;
                            end
                            else
                            begin
                                seq_next = seq_reg + 7'd1;
                                ms_next = '0;
                                mode_next = MODE_PAYLOAD;
                            end
                        end
                    end
                    else if (pos_reg == PW'(6))
                    begin
                        ch = hdr_next[55:24];
                        cmd = hdr_next[22:16];
                        len = hdr_next[15:0];
                        mode_next = MODE_DISCARD;
                        if (cmd == CMD_INIT)
                        begin
                            if (len != 16'd8)
                            begin
                                e[0] = mk_ev(KIND_ERROR, ch, ERR_LEN, '0, '0, '0);
                                n = 2'd1;
                            end
                            else
                            begin
                                nonce_next = '0;
                                mode_next = MODE_NONCE;
                            end
                        end
                        else if (ch == BROADCAST_CH)
                        begin
                            e[0] = mk_ev(KIND_ERROR, ch, ERR_CHANNEL, '0, '0, '0);
                            n = 2'd1;
                        end
                        else if (ach_reg != '0 && ch != ach_reg)
                        begin
                            e[0] = mk_ev(KIND_ERROR, ch, ERR_BUSY, '0, '0, '0);
                            n = 2'd1;
                        end
                        else
                        begin
                            ach_next = ch; acmd_next = cmd; exp_next = len;
                            rcv_next = '0; seq_next = '0;
                            ovf_next = len > {3'b0, maxlen_reg};
                            ms_next = '0;
                            if (len == '0)
                            begin
                                if (ovf_next)
                                    e[0] = mk_ev(KIND_ERROR, ch, ERR_LEN, '0, '0, '0);
                                else
                                    e[0] = mk_ev(KIND_COMPLETE, ch, cmd, '0, '0, '0);
                                n = 2'd1;
                                ach_next = '0; acmd_next = '0; exp_next = '0;
                                ovf_next = 1'b0;
                            end
                            else
                                mode_next = MODE_PAYLOAD;
                        end
                    end
                end
                MODE_NONCE:
                begin
                    k = 3'(pos_reg - PW'(7));
                    nonce_next = nonce_reg | ({56'b0, d} << (6'd56 - {k, 3'b0}));
                    if (pos_reg == PW'(14) || pos_reg == LAST_POS)
                    begin
                        ch = hdr_reg[55:24];
                        if (ch == BROADCAST_CH)
                        begin
                            fi = free_reg + 32'd1;
                            free_next = (fi == BROADCAST_CH || fi == '0) ? 32'd1 : fi;
                            e[0] = mk_ev(KIND_INIT, ch, '0, '0, nonce_next, free_reg);
                        end
                        else
                        begin
                            if (ch == ach_reg)
                            begin
                                ach_next = '0; acmd_next = '0; exp_next = '0;
                                rcv_next = '0; seq_next = '0; ovf_next = 1'b0;
                            end
                            e[0] = mk_ev(KIND_INIT, ch, '0, '0, nonce_next, ch);
                        end
                        n = 2'd1;
                        mode_next = MODE_DISCARD;
                    end
                end
                MODE_PAYLOAD:
                begin
                    if (ach_reg != '0 && rcv_reg < exp_reg)
                    begin
                        rinc = rcv_reg + 16'd1;
                        rcv_next = rinc;
                        if (!ovf_reg)
                        begin
                            e[0] = mk_ev(KIND_PAYLOAD, ach_reg, d[6:0], {5'b0, d}, '0, '0);
                            n = 2'd1;
                        end
                        if (rinc >= exp_reg)
                        begin
                            if (ovf_reg)
                                e[n[0]] = mk_ev(KIND_ERROR, ach_reg, ERR_LEN, '0, '0, '0);
                            else
                                e[n[0]] = mk_ev(KIND_COMPLETE, ach_reg, acmd_reg,
                                                rinc[12:0], '0, '0);
                            n = n + 2'd1;
                            ach_next = '0; acmd_next = '0; exp_next = '0; rcv_next = '0;
                            seq_next = '0; ovf_next = 1'b0;
                            mode_next = MODE_DISCARD;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (pos_reg >= LAST_POS)
            begin
                pos_next = '0;
                mode_next = MODE_HEADER;
                hdr_next = '0;
            end
            else
                pos_next = pos_reg + PW'(1);
        end
        if (n == 2'd2)
            e[1].last = 1'b1;
        else
            e[0].last = 1'b1;
        ev0 = e[0];
        ev1 = e[1];
        nev = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= FRAME_TIMEOUT_RST;
            maxlen_reg <= MAX_LEN_RST;
            pos_reg <= '0;
            hdr_reg <= '0;
            mode_reg <= MODE_HEADER;
            ach_reg <= '0;
            acmd_reg <= '0;
            exp_reg <= '0;
            rcv_reg <= '0;
            seq_reg <= '0;
            ovf_reg <= 1'b0;
            ms_reg <= '0;
            free_reg <= 32'd1;
            nonce_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.payload.index)
                    REG_TIMEOUT: timeout_reg <= cfg.payload.data;
                    REG_MAXLEN:  maxlen_reg <= cfg.payload.data[12:0];
                    default: ;
                endcase
            end
            if (acc)
            begin
                pos_reg <= pos_next;
                hdr_reg <= hdr_next;
                mode_reg <= mode_next;
                ach_reg <= ach_next;
                acmd_reg <= acmd_next;
                exp_reg <= exp_next;
                rcv_reg <= rcv_next;
                seq_reg <= seq_next;
                ovf_reg <= ovf_next;
                ms_reg <= ms_next;
                free_reg <= free_next;
                nonce_reg <= nonce_next;
            end
            cnt_reg <= cnt_reg - ((out_ch.valid && out_ch.ready) ? 2'd1 : 2'd0)
                       + (acc ? nev : 2'd0);
        end
    end

    // Queue payload: entry 0 is the head.
    always_ff @(posedge clk)
    begin
        logic [1:0] base;
        base = cnt_reg - ((out_ch.valid && out_ch.ready) ? 2'd1 : 2'd0);
        if (acc && nev != 2'd0 && base == 2'd0)
        begin
            q_reg[0] <= ev0;
            q_reg[1] <= ev1;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                q_reg[0] <= q_reg[1];
            if (acc && nev != 2'd0)
                q_reg[1] <= ev0;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("result queue overfilled");
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ch.ready)
        else $error("input accepted with full queue");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= LAST_POS)
        else $error("byte position out of range");
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ach_reg == '0 |-> (!ovf_reg && exp_reg == '0))
        else $error("stale message state while idle");

endmodule
